// ===== hdl/bfa_pkg.sv =====
// Shared constants and control types of the best-fit block allocator.
package bfa_pkg;

    localparam int NUM_BLOCKS = 8;
    localparam int SIZE_BITS  = 16;
    localparam int ADDR_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam int IDX_BITS   = 3;
    localparam int SZIN_BITS  = 16;
    localparam int SPACE_BITS = 16;
    localparam int TOTAL_BITS = 19;
    localparam int SUM_BITS   = 20;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef struct packed {
        logic capture;
        logic load_rd;
        logic scan_rd;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/bfa_if.sv =====
// Request and result channel interfaces of the best-fit block allocator.
interface bfa_req_if;
    import bfa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 mode;
    logic [IDX_BITS-1:0]  block_index;
    logic [SZIN_BITS-1:0] size_value;

    modport source (output valid, output mode, output block_index, output size_value,
                    input ready);
    modport sink   (input valid, input mode, input block_index, input size_value,
                    output ready);
endinterface

interface bfa_res_if;
    import bfa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  allocated;
    logic [IDX_BITS-1:0]   chosen_block;
    logic [SPACE_BITS-1:0] space_left;
    logic [TOTAL_BITS-1:0] total_free;

    modport source (output valid, output allocated, output chosen_block,
                    output space_left, output total_free, input ready);
    modport sink   (input valid, input allocated, input chosen_block,
                    input space_left, input total_free, output ready);
endinterface

// ===== hdl/bfa_ctrl.sv =====
// Sequencer of the best-fit block allocator: load, scan and commit steps.
module bfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_mode,
    output logic             o_req_ready,
    output bfa_pkg::t_dp_cmd o_cmd,
    input  bfa_pkg::t_dp_sts i_sts
);
    import bfa_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LDRD   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_req_ready   = 1'b0;
        o_cmd         = '0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_req_mode == MODE_REQUEST) ? ST_SCAN : ST_LDRD;
                end
            end
            ST_LDRD: begin
                o_cmd.load_rd = 1'b1;
                n_state = ST_COMMIT;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_scan_to_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_sts.scan_last) |=> (r_state == ST_DRAIN))
        else $error("scan did not stop after the last block");
    a_commit_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_state == ST_IDLE))
        else $error("commit did not return to idle");
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !o_cmd.commit && !o_cmd.scan_rd && !o_cmd.load_rd)
        else $error("request taken while an item is in progress");
`endif

endmodule

// ===== hdl/bfa_dp.sv =====
// Datapath of the best-fit block allocator: space table, scan compare, total, result register.
module bfa_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bfa_pkg::t_dp_cmd             i_cmd,
    output bfa_pkg::t_dp_sts             o_sts,
    input  logic                         i_mode,
    input  logic [bfa_pkg::IDX_BITS-1:0] i_block_index,
    input  logic [bfa_pkg::SZIN_BITS-1:0] i_size_value,
    bfa_res_if.source                    o_res
);
    import bfa_pkg::*;

    function automatic logic [SUM_BITS-1:0] to_sum(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS+SUM_BITS-1:0] w;
        w = {{SUM_BITS{1'b0}}, v};
        return w[SUM_BITS-1:0];
    endfunction

    function automatic logic [SPACE_BITS-1:0] to_space(input logic [SIZE_BITS-1:0] v);
        logic [SIZE_BITS+SPACE_BITS-1:0] w;
        w = {{SPACE_BITS{1'b0}}, v};
        return w[SPACE_BITS-1:0];
    endfunction

    function automatic logic [IDX_BITS-1:0] to_idx(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS+IDX_BITS-1:0] w;
        w = {{IDX_BITS{1'b0}}, a};
        return w[IDX_BITS-1:0];
    endfunction

    // Space table with one valid bit per entry; an entry never loaded reads zero.
    logic [SIZE_BITS-1:0]  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;

    logic                  r_mode;
    logic [ADDR_BITS-1:0]  r_addr;
    logic                  r_in_range;
    logic [SIZE_BITS-1:0]  r_size;

    logic [ADDR_BITS-1:0]  r_cnt;
    logic [ADDR_BITS-1:0]  r_cmp_idx;
    logic                  r_cmp_pend;
    logic                  r_found;
    logic [ADDR_BITS-1:0]  r_best_idx;
    logic [SIZE_BITS-1:0]  r_best_val;

    logic [SUM_BITS-1:0]   r_sum;
    logic [SUM_BITS-1:0]   n_sum;

    logic                  r_out_valid;
    logic                  r_out_alloc;
    logic [IDX_BITS-1:0]   r_out_blk;
    logic [SPACE_BITS-1:0] r_out_left;
    logic [TOTAL_BITS-1:0] r_out_total;

    logic [ADDR_BITS+IDX_BITS-1:0]  w_idx_ext;
    logic [SIZE_BITS+SZIN_BITS-1:0] w_size_ext;
    logic [SIZE_BITS-1:0]  w_rd_val;
    logic                  w_rd_en;
    logic [ADDR_BITS-1:0]  w_rd_addr;
    logic                  w_wr_en;
    logic [ADDR_BITS-1:0]  w_wr_addr;
    logic [SIZE_BITS-1:0]  w_wr_data;
    logic                  w_alloc;
    logic [IDX_BITS-1:0]   w_blk;
    logic [SPACE_BITS-1:0] w_left;

    assign w_idx_ext  = {{ADDR_BITS{1'b0}}, i_block_index};
    assign w_size_ext = {{SIZE_BITS{1'b0}}, i_size_value};
    assign w_rd_val   = r_rd_vld ? r_rd_data : '0;
    assign w_rd_en    = i_cmd.scan_rd || (i_cmd.load_rd && r_in_range);
    assign w_rd_addr  = i_cmd.load_rd ? r_addr : r_cnt;

    assign o_sts.scan_last = (r_cnt == ADDR_BITS'(NUM_BLOCKS - 1));
    assign o_sts.out_free  = !r_out_valid || o_res.ready;

    // Captured item fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode     <= i_mode;
            r_addr     <= w_idx_ext[ADDR_BITS-1:0];
            r_in_range <= (w_idx_ext < (ADDR_BITS+IDX_BITS)'(NUM_BLOCKS));
            r_size     <= w_size_ext[SIZE_BITS-1:0];
        end
    end

    // Table storage and registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr_en) begin
            r_vld[w_wr_addr] <= 1'b1;
        end
    end

    // Scan: one table read per cycle, each compared in the cycle after its read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_cmp_pend <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_cmp_pend <= i_cmd.scan_rd;
            if (i_cmd.capture) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (r_cmp_pend && (w_rd_val >= r_size) &&
                    (!r_found || (w_rd_val < r_best_val))) begin
                    r_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_cmp_idx <= r_cnt;
        end
        if (r_cmp_pend && (w_rd_val >= r_size) &&
            (!r_found || (w_rd_val < r_best_val))) begin
            r_best_idx <= r_cmp_idx;
            r_best_val <= w_rd_val;
        end
    end

    // Commit: table write-back, running total and result.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_addr;
        w_wr_data = r_size;
        n_sum     = r_sum;
        w_alloc   = 1'b0;
        w_blk     = '0;
        w_left    = '0;
        if (i_cmd.commit) begin
            if (r_mode == MODE_LOAD) begin
                if (r_in_range) begin
                    w_wr_en = 1'b1;
                    n_sum   = r_sum - to_sum(w_rd_val) + to_sum(r_size);
                    w_alloc = 1'b1;
                    w_blk   = to_idx(r_addr);
                    w_left  = to_space(r_size);
                end
            end else if (r_found) begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_best_idx;
                w_wr_data = r_best_val - r_size;
                n_sum     = r_sum - to_sum(r_size);
                w_alloc   = 1'b1;
                w_blk     = to_idx(r_best_idx);
                w_left    = to_space(r_best_val - r_size);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum <= n_sum;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_alloc <= w_alloc;
            r_out_blk   <= w_blk;
            r_out_left  <= w_left;
            r_out_total <= n_sum[TOTAL_BITS-1:0];
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.allocated    = r_out_alloc;
    assign o_res.chosen_block = r_out_blk;
    assign o_res.space_left   = r_out_left;
    assign o_res.total_free   = r_out_total;

`ifndef SYNTHESIS
    a_commit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || o_res.ready))
        else $error("result overwritten before it was taken");
    a_best_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && !i_cmd.capture) |-> (r_best_val >= r_size))
        else $error("chosen block is smaller than the request");
    a_capture_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.capture |=> (!r_found && r_cnt == '0))
        else $error("scan state not cleared on a new request");
`endif

endmodule

// ===== hdl/best_fit_block_allocator.sv =====
// Top level of the best-fit block allocator: sequencer plus datapath.
// Usage:
// The block keeps a table of free space for eight memory blocks, cleared to zero
// by reset. Items arrive on i_req (valid/ready); an item is taken on a clock edge
// where valid and ready are both high. A load item (mode 0) sets the space of the
// block named by block_index to size_value. An allocation request (mode 1) picks
// the block with the smallest space that still holds size_value, the lowest index
// on a tie, and takes the request out of it. Every request yields exactly one
// result on o_res: allocated flag, chosen block, space left in it and the total
// free space over all blocks.
// Sequence: a load reads its block once and then commits; the next request is taken
// only after that commit, once the sequencer is back in idle. An allocation reads
// the table one block per cycle through the single read port, compares the last
// block in the cycle after its read and then commits, and likewise the next request
// is taken only after that commit.
// A finished result waits in an output register; the next request is already
// taken and worked on while the receiver stalls, and only its final commit
// waits until the earlier result has left. Reset is synchronous, active low,
// and clears the table, the total and the output valid.
module best_fit_block_allocator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_res_if.source  o_res
);
    import bfa_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_mode  (i_req.mode),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bfa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_mode        (i_req.mode),
        .i_block_index (i_req.block_index),
        .i_size_value  (i_req.size_value),
        .o_res         (o_res)
    );

endmodule
